FILE: rtl/rlepd_pkg.sv
// rlepd_pkg: shared types and constants for the run-length plane decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rlepd_pkg;

    localparam int DataW   = 8;
    localparam int CountW  = 7;
    localparam int WordW   = 16;
    localparam int QDepth  = 4;
    localparam int QPtrW   = $clog2(QDepth);
    localparam int QCountW = $clog2(QDepth + 1);

    localparam logic [WordW-1:0] PLANE_BYTES_RESET = 16'd8000;
    localparam logic [WordW-1:0] DEST_BASE_RESET   = 16'd0;
    localparam logic [WordW-1:0] CONSUMED_MAX      = 16'hFFFF;

    // configuration register indexes
    localparam logic CFG_PLANE_BYTES = 1'b0;
    localparam logic CFG_DEST_BASE   = 1'b1;

    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_REP  = 2'd2
    } phase_t;

    // one classified source byte as it sits in the queue
    typedef struct packed {
        logic [DataW-1:0]  value;
        logic [CountW-1:0] count;
        logic              is_repeat;
        logic              last;
    } src_item_t;

endpackage

FILE: rtl/rlepd_front.sv
// rlepd_front: accepts source bytes, splits control fields and queues them
// depends on rlepd_pkg
`timescale 1ns / 1ps

module rlepd_front
    import rlepd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             src_valid,
    output logic             src_ready,
    input  logic [DataW-1:0] data_byte,
    input  logic             last_byte,
    output logic             head_valid,
    output src_item_t        head_item,
    input  logic             head_pop
);

    src_item_t             queue_mem [QDepth];
    logic [QPtrW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCountW-1:0]    fill_reg, fill_next;
    src_item_t             new_item;
    logic                  push;
    logic                  pop;

    // classify: top bit marks a repeat control, low bits are the count either way
    always_comb
    begin
        new_item.value     = data_byte;
        new_item.count     = data_byte[CountW-1:0];
        new_item.is_repeat = data_byte[DataW-1];
        new_item.last      = last_byte;
    end

    assign src_ready  = (fill_reg != QCountW'(QDepth));
    assign head_valid = (fill_reg != '0);
    assign head_item  = queue_mem[rd_ptr_reg];
    assign push       = src_valid && src_ready;
    assign pop        = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

FILE: rtl/rlepd_back.sv
// rlepd_back: decode state, plane bookkeeping, config registers, result register
// depends on rlepd_pkg
`timescale 1ns / 1ps

module rlepd_back
    import rlepd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_index,
    input  logic [WordW-1:0]  cfg_data,
    input  logic              head_valid,
    input  src_item_t         head_item,
    output logic              head_pop,
    output logic              run_valid,
    input  logic              run_ready,
    output logic [DataW-1:0]  run_value,
    output logic [CountW-1:0] run_length,
    output logic [WordW-1:0]  run_address,
    output logic              plane_end,
    output logic              truncated,
    output logic [WordW-1:0]  src_used
);

    logic [WordW-1:0]  plane_bytes_reg;
    logic [WordW-1:0]  dest_base_reg;

    phase_t            phase_reg, phase_next;
    logic [CountW-1:0] lit_left_reg, lit_left_next;
    logic [CountW-1:0] rep_pending_reg, rep_pending_next;
    logic [WordW-1:0]  decoded_reg, decoded_next;
    logic [WordW-1:0]  consumed_reg, consumed_next;

    logic              out_valid_reg, out_valid_next;
    logic [DataW-1:0]  out_value_reg;
    logic [CountW-1:0] out_length_reg;
    logic [WordW-1:0]  out_address_reg;
    logic              out_end_reg;
    logic              out_trunc_reg;
    logic [WordW-1:0]  out_used_reg;

    logic [WordW-1:0]  room;
    logic [WordW-1:0]  consumed_inc;
    logic [WordW-1:0]  decoded_step;
    logic [CountW-1:0] room_clamp;
    logic [CountW-1:0] r_len;
    logic [CountW-1:0] clamped;
    logic              r_end;
    logic              r_trunc;
    logic              has_result;

    assign head_pop = head_valid && (!out_valid_reg || run_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_bytes_reg <= PLANE_BYTES_RESET;
            dest_base_reg   <= DEST_BASE_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_PLANE_BYTES: plane_bytes_reg <= cfg_data;
                CFG_DEST_BASE:   dest_base_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // plane space left, also saturated to a count width, and the next consumed count
    always_comb
    begin
        room = (decoded_reg >= plane_bytes_reg) ? '0 : plane_bytes_reg - decoded_reg;
        room_clamp = (room > WordW'({CountW{1'b1}})) ? {CountW{1'b1}} : room[CountW-1:0];
        consumed_inc = (consumed_reg == CONSUMED_MAX) ? consumed_reg : consumed_reg + 1'b1;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        lit_left_next    = lit_left_reg;
        rep_pending_next = rep_pending_reg;
        r_len            = '0;
        clamped          = '0;

        unique case (phase_reg)
            PH_LIT:
            begin
                if (room != '0 && lit_left_reg != '0)
                begin
                    r_len = CountW'(1);
                end
                if (lit_left_reg != '0)
                begin
                    lit_left_next = lit_left_reg - 1'b1;
                end
                if (lit_left_next == '0)
                begin
                    phase_next = PH_CTRL;
                end
            end
            PH_REP:
            begin
                r_len            = (rep_pending_reg > room_clamp) ? room_clamp : rep_pending_reg;
                rep_pending_next = '0;
                phase_next       = PH_CTRL;
            end
            default:
            begin
                if (!head_item.is_repeat)
                begin
                    clamped       = (head_item.count > room_clamp) ? room_clamp : head_item.count;
                    lit_left_next = clamped;
                    phase_next    = (clamped != '0) ? PH_LIT : PH_CTRL;
                end
                else
                begin
                    rep_pending_next = head_item.count;
                    phase_next       = PH_REP;
                end
            end
        endcase

        decoded_step = decoded_reg + WordW'(r_len);
        r_end        = (decoded_step >= plane_bytes_reg);
        r_trunc      = !r_end && head_item.last;
        has_result   = (r_len != '0) || r_end || r_trunc;

        decoded_next  = decoded_step;
        consumed_next = consumed_inc;
        if (r_end || r_trunc)
        begin
            phase_next       = PH_CTRL;
            lit_left_next    = '0;
            rep_pending_next = '0;
            decoded_next     = '0;
            consumed_next    = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !run_ready;
        if (head_pop)
        begin
            out_valid_next = has_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_CTRL;
            lit_left_reg    <= '0;
            rep_pending_reg <= '0;
            decoded_reg     <= '0;
            consumed_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (head_pop)
            begin
                phase_reg       <= phase_next;
                lit_left_reg    <= lit_left_next;
                rep_pending_reg <= rep_pending_next;
                decoded_reg     <= decoded_next;
                consumed_reg    <= consumed_next;
            end
        end
    end

    // result payload; fields without a run or an end read as zero
    always_ff @(posedge clk)
    begin
        if (head_pop && has_result)
        begin
            out_value_reg   <= (r_len != '0) ? head_item.value : '0;
            out_length_reg  <= r_len;
            out_address_reg <= (r_len != '0) ? dest_base_reg + decoded_reg : '0;
            out_end_reg     <= r_end;
            out_trunc_reg   <= r_trunc;
            out_used_reg    <= (r_end || r_trunc) ? consumed_inc : '0;
        end
    end

    assign run_valid   = out_valid_reg;
    assign run_value   = out_value_reg;
    assign run_length  = out_length_reg;
    assign run_address = out_address_reg;
    assign plane_end   = out_end_reg;
    assign truncated   = out_trunc_reg;
    assign src_used    = out_used_reg;

endmodule

FILE: rtl/rle_plane_decoder.sv
// rle_plane_decoder: top level of the run-length plane decoder
// depends on rlepd_pkg, rlepd_front, rlepd_back
`timescale 1ns / 1ps

// Takes one compressed source byte per cycle while the queue has room
// and delivers at most one run descriptor per byte through a registered
// output. A byte is held in a four-entry queue after it is classified;
// the decode stage retires one queued byte per cycle whenever the output
// register is empty or being taken, so throughput is one byte per clock
// while the output is not stalled; a result passes the queue and then
// the output register. Configuration writes take effect on the next
// cycle and should only be made while no bytes are in flight.
module rle_plane_decoder
    import rlepd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_index,
    input  logic [WordW-1:0]  cfg_data,
    input  logic              src_valid,
    output logic              src_ready,
    input  logic [DataW-1:0]  data_byte,
    input  logic              last_byte,
    output logic              run_valid,
    input  logic              run_ready,
    output logic [DataW-1:0]  run_value,
    output logic [CountW-1:0] run_length,
    output logic [WordW-1:0]  run_address,
    output logic              plane_end,
    output logic              truncated,
    output logic [WordW-1:0]  src_used
);

    logic      head_valid;
    src_item_t head_item;
    logic      head_pop;

    rlepd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop)
    );

    rlepd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .head_pop     (head_pop),
        .run_valid    (run_valid),
        .run_ready    (run_ready),
        .run_value    (run_value),
        .run_length   (run_length),
        .run_address  (run_address),
        .plane_end    (plane_end),
        .truncated    (truncated),
        .src_used     (src_used)
    );

endmodule

FILE: rtl/rlepd_checker.sv
// rlepd_checker: port-level checks on the run-length plane decoder results
// depends on rlepd_pkg; bound to rle_plane_decoder
`timescale 1ns / 1ps

module rlepd_checker
    import rlepd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              run_valid,
    input logic              run_ready,
    input logic [DataW-1:0]  run_value,
    input logic [CountW-1:0] run_length,
    input logic [WordW-1:0]  run_address,
    input logic              plane_end,
    input logic              truncated,
    input logic [WordW-1:0]  src_used
);

    // a stalled result holds until transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && !run_ready |=> run_valid && $stable(run_value)
            && $stable(run_length) && $stable(run_address) && $stable(plane_end)
            && $stable(truncated) && $stable(src_used))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid |-> (run_length != '0) || plane_end || truncated)
        else $error("empty result delivered");

    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid |-> !(plane_end && truncated))
        else $error("plane end and truncation together");

    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run_length == '0 |-> run_value == '0 && run_address == '0)
        else $error("run fields set without a run");

    assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && !plane_end && !truncated |-> src_used == '0)
        else $error("consumed count outside plane end");

endmodule

bind rle_plane_decoder rlepd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .run_valid   (run_valid),
    .run_ready   (run_ready),
    .run_value   (run_value),
    .run_length  (run_length),
    .run_address (run_address),
    .plane_end   (plane_end),
    .truncated   (truncated),
    .src_used    (src_used)
);

FILE: dv/tb_rle_plane_decoder.sv
// tb_rle_plane_decoder: self-checking testbench for the run-length plane decoder
// predicts every run descriptor from the source bytes and checks it at the output
// depends on rlepd_pkg and rle_plane_decoder
`timescale 1ns / 1ps

module tb_rle_plane_decoder;
    import rlepd_pkg::*;

    localparam logic [DataW-1:0] REPEAT_FLAG = 8'h80;
    localparam int REPEAT_BIAS   = 128;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 120;

    typedef struct {
        logic [DataW-1:0]  value;
        logic [CountW-1:0] length;
        logic [WordW-1:0]  address;
        logic              plane_end;
        logic              truncated;
        logic [WordW-1:0]  consumed;
    } run_desc_t;

    class run_scoreboard;
        int plane_bytes;
        int dest_base;
        phase_t phase;
        int literal_left;
        int repeat_pending;
        int decoded;
        int consumed;
        int errors;
        run_desc_t expected_runs[$];

        function new();
            plane_bytes = int'(PLANE_BYTES_RESET);
            dest_base = int'(DEST_BASE_RESET);
            errors = 0;
            restart_plane();
        endfunction

        function void restart_plane();
            phase = PH_CTRL;
            literal_left = 0;
            repeat_pending = 0;
            decoded = 0;
            consumed = 0;
        endfunction

        function void set_reg(logic idx, logic [WordW-1:0] val);
            if (idx == CFG_PLANE_BYTES)
                plane_bytes = int'(val);
            else
                dest_base = int'(val);
        endfunction

        // advance the decoder state by one source byte, queue the run it causes
        function void note_byte(logic [DataW-1:0] b, logic lst);
            int room;
            int cnt;
            run_desc_t r;
            r = '{value: '0, length: '0, address: '0, plane_end: 1'b0,
                  truncated: 1'b0, consumed: '0};
            room = (decoded >= plane_bytes) ? 0 : plane_bytes - decoded;
            if (consumed < int'(CONSUMED_MAX))
                consumed++;
            case (phase)
                PH_LIT:
                begin
                    if (room > 0 && literal_left > 0)
                    begin
                        r.value = b;
                        r.length = CountW'(1);
                        r.address = WordW'(dest_base + decoded);
                        decoded++;
                    end
                    if (literal_left > 0)
                        literal_left--;
                    if (literal_left == 0)
                        phase = PH_CTRL;
                end
                PH_REP:
                begin
                    cnt = (repeat_pending > room) ? room : repeat_pending;
                    if (cnt > 0)
                    begin
                        r.value = b;
                        r.length = CountW'(cnt);
                        r.address = WordW'(dest_base + decoded);
                        decoded += cnt;
                    end
                    repeat_pending = 0;
                    phase = PH_CTRL;
                end
                default:
                begin
                    if (b < REPEAT_FLAG)
                    begin
                        literal_left = (int'(b) > room) ? room : int'(b);
                        phase = (literal_left > 0) ? PH_LIT : PH_CTRL;
                    end
                    else
                    begin
                        repeat_pending = int'(b) - REPEAT_BIAS;
                        phase = PH_REP;
                    end
                end
            endcase
            if (decoded >= plane_bytes)
            begin
                r.plane_end = 1'b1;
                r.consumed = WordW'(consumed);
                restart_plane();
            end
            else if (lst)
            begin
                r.truncated = 1'b1;
                r.consumed = WordW'(consumed);
                restart_plane();
            end
            if (r.length != 0 || r.plane_end || r.truncated)
                expected_runs.push_back(r);
        endfunction

        function void cmp_field(string name, int exp_val, int act_val);
            if (exp_val != act_val)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_run(run_desc_t act);
            run_desc_t exp_run;
            if (expected_runs.size() == 0)
            begin
                $display("%0t: unexpected run, expected none actual value %0h length %0d",
                         $time, act.value, act.length);
                errors++;
                return;
            end
            exp_run = expected_runs.pop_front();
            cmp_field("run_value", int'(exp_run.value), int'(act.value));
            cmp_field("run_length", int'(exp_run.length), int'(act.length));
            cmp_field("run_address", int'(exp_run.address), int'(act.address));
            cmp_field("plane_end", int'(exp_run.plane_end), int'(act.plane_end));
            cmp_field("truncated", int'(exp_run.truncated), int'(act.truncated));
            cmp_field("src_used", int'(exp_run.consumed), int'(act.consumed));
        endfunction

        function int pending();
            return expected_runs.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write_en = 1'b0;
    logic              cfg_index = CFG_PLANE_BYTES;
    logic [WordW-1:0]  cfg_data = '0;
    logic              src_valid = 1'b0;
    logic              src_ready;
    logic [DataW-1:0]  data_byte = '0;
    logic              last_byte = 1'b0;
    logic              run_valid;
    logic              run_ready = 1'b0;
    logic [DataW-1:0]  run_value;
    logic [CountW-1:0] run_length;
    logic [WordW-1:0]  run_address;
    logic              plane_end;
    logic              truncated;
    logic [WordW-1:0]  src_used;

    run_scoreboard sb;
    int src_gap_max = 8;
    int rcv_gap_max = 8;
    bit hold_req = 1'b0;
    int cycles = 0;

    rle_plane_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .src_valid    (src_valid),
        .src_ready    (src_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .run_valid    (run_valid),
        .run_ready    (run_ready),
        .run_value    (run_value),
        .run_length   (run_length),
        .run_address  (run_address),
        .plane_end    (plane_end),
        .truncated    (truncated),
        .src_used     (src_used)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && run_valid && run_ready)
            sb.check_run('{value: run_value, length: run_length, address: run_address,
                           plane_end: plane_end, truncated: truncated,
                           consumed: src_used});
    end

    // output side: random stall after each transfer, long hold on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (run_valid && run_ready)
                stall_left = (rcv_gap_max == 0) ? 0 : $urandom_range(0, rcv_gap_max);
            if (hold_req)
            begin
                stall_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                run_ready <= 1'b0;
                stall_left--;
            end
            else
                run_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic idx, logic [WordW-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays up across back-to-back transfers
    task automatic send_byte(logic [DataW-1:0] b, logic lst);
        int gap;
        gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        sb.note_byte(b, lst);
    endtask

    // bytes without a run may still be in flight after the last result
    task automatic drain_idle();
        src_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic rare_last();
        return ($urandom_range(0, 199) == 0);
    endfunction

    // one mostly well-formed piece of compressed stream with random content
    task automatic send_sequence(inout int sent);
        int kind;
        int cnt;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
            send_byte(DataW'(cnt), rare_last());
            sent++;
            for (int i = 0; i < cnt; i++)
            begin
                send_byte(DataW'($urandom_range(0, 255)), rare_last());
                sent++;
            end
        end
        else if (kind < 85)
        begin
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 20);
            send_byte(REPEAT_FLAG + DataW'(cnt), rare_last());
            send_byte(DataW'($urandom_range(0, 255)), rare_last());
            sent += 2;
        end
        else if (kind < 93)
        begin
            send_byte(DataW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            sent++;
        end
        else
        begin
            // literal group cut short by the end of the source
            send_byte(DataW'($urandom_range(3, 127)), 1'b0);
            send_byte(DataW'($urandom_range(0, 255)), 1'b0);
            send_byte(DataW'($urandom_range(0, 255)), 1'b1);
            sent += 3;
        end
    endtask

    initial
    begin : stimulus
        int sent;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small plane whose addresses wrap past the top
        write_reg(CFG_PLANE_BYTES, 16'd6);
        write_reg(CFG_DEST_BASE, 16'hFFFE);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h83, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'h05, 1'b1);
        send_byte(8'h81, 1'b1);

        // plane shrunk while literals are still announced
        drain_idle();
        write_reg(CFG_PLANE_BYTES, 16'd10);
        write_reg(CFG_DEST_BASE, 16'd0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        drain_idle();
        write_reg(CFG_PLANE_BYTES, 16'd3);
        send_byte(8'h03, 1'b0);

        // plane shrunk below what is already decoded, then size zero
        send_byte(8'h82, 1'b0);
        send_byte(8'h44, 1'b0);
        drain_idle();
        write_reg(CFG_PLANE_BYTES, 16'd1);
        send_byte(8'h10, 1'b0);
        drain_idle();
        write_reg(CFG_PLANE_BYTES, 16'd0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h90, 1'b1);

        // random phases over several plane sizes and bases
        for (int p = 0; p < 6; p++)
        begin
            drain_idle();
            case (p)
                0:
                begin
                    write_reg(CFG_PLANE_BYTES, 16'd64);
                    write_reg(CFG_DEST_BASE, 16'hFFC0);
                end
                1:
                begin
                    write_reg(CFG_PLANE_BYTES, 16'd1);
                    write_reg(CFG_DEST_BASE, WordW'($urandom_range(0, 65535)));
                end
                2:
                begin
                    write_reg(CFG_PLANE_BYTES, 16'hFFFF);
                    write_reg(CFG_DEST_BASE, WordW'($urandom_range(0, 65535)));
                end
                3:
                begin
                    write_reg(CFG_PLANE_BYTES, WordW'($urandom_range(1, 300)));
                    write_reg(CFG_DEST_BASE, WordW'($urandom_range(0, 65535)));
                end
                4:
                begin
                    write_reg(CFG_PLANE_BYTES, 16'd200);
                    write_reg(CFG_DEST_BASE, 16'd0);
                end
                default:
                begin
                    write_reg(CFG_PLANE_BYTES, WordW'($urandom_range(20, 1000)));
                    write_reg(CFG_DEST_BASE, 16'hFFFF);
                end
            endcase
            src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            rcv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            sent = 0;
            while (sent < 140)
                send_sequence(sent);
        end

        // long output hold while the source keeps streaming literals
        drain_idle();
        write_reg(CFG_PLANE_BYTES, 16'hFFFF);
        write_reg(CFG_DEST_BASE, 16'd0);
        src_gap_max = 0;
        rcv_gap_max = 8;
        hold_req = 1'b1;
        send_byte(8'd30, 1'b0);
        for (int i = 0; i < 30; i++)
            send_byte(DataW'($urandom_range(0, 255)), 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'h3C, 1'b1);

        drain_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
